>>> hdl/stt_pkg.sv
// ----------------------------------------------------------------------------
// Source text tokenizer package
// Shared widths, token kinds, scanner modes, character tables and payload types.
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int POS_BITS     = 20;
  localparam int LEN_BITS     = POS_BITS + 1;
  localparam int KIND_BITS    = 6;
  localparam int KW_LEN_MAX   = 9;
  localparam int KW_BITS      = KW_LEN_MAX * 8;
  localparam int NUM_KEYWORDS = 16;
  localparam int NUM_PUNCT    = 16;
  localparam int QUEUE_DEPTH  = 4;

  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};
  localparam logic [LEN_BITS-1:0] LEN_MAX = {1'b1, {POS_BITS{1'b0}}};

  localparam logic [KIND_BITS-1:0] KIND_KEYWORD_BASE = 6'd16;
  localparam logic [KIND_BITS-1:0] KIND_INT          = 6'd32;
  localparam logic [KIND_BITS-1:0] KIND_REAL         = 6'd33;
  localparam logic [KIND_BITS-1:0] KIND_CHAR         = 6'd34;
  localparam logic [KIND_BITS-1:0] KIND_STRING       = 6'd35;
  localparam logic [KIND_BITS-1:0] KIND_IDENT        = 6'd36;
  localparam logic [KIND_BITS-1:0] KIND_END          = 6'd37;

  localparam logic [7:0] CH_QUOTE      = 8'h27;
  localparam logic [7:0] CH_DQUOTE     = 8'h22;
  localparam logic [7:0] CH_DOT        = 8'h2e;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5f;

  typedef enum logic [2:0] {
    MODE_BEGIN,
    MODE_SKIP,
    MODE_WORD,
    MODE_INTEGER,
    MODE_REAL,
    MODE_CHAR,
    MODE_STRING
  } mode_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic       final_symbol;
  } in_t;

  typedef struct packed {
    logic [KIND_BITS-1:0] token_kind;
    logic [POS_BITS-1:0]  token_start;
    logic [LEN_BITS-1:0]  token_length;
    logic                 run_end;
  } out_t;

  typedef struct packed {
    out_t [2:0] tok;
    logic [1:0] count;
  } batch_t;

  typedef logic [KW_LEN_MAX-1:0][7:0] word_t;

  // Entry i is the character of punctuation kind i.
  localparam logic [NUM_PUNCT-1:0][7:0] PUNCT_CHARS = {
    8'h3e, 8'h3c, 8'h3d, 8'h2a, 8'h2f, 8'h2d, 8'h2b, 8'h3a,
    8'h2e, 8'h2c, 8'h7e, 8'h0a, 8'h5d, 8'h5b, 8'h29, 8'h28
  };

  // Entry i is keyword kind 16 + i, right aligned, first character highest.
  localparam logic [NUM_KEYWORDS-1:0][KW_BITS-1:0] KEYWORD_TEXT = {
    KW_BITS'("while"),  KW_BITS'("else"),   KW_BITS'("if"),        KW_BITS'("private"),
    KW_BITS'("const"),  KW_BITS'("static"), KW_BITS'("array"),     KW_BITS'("end"),
    KW_BITS'("return"), KW_BITS'("interface"), KW_BITS'("struct"), KW_BITS'("module"),
    KW_BITS'("or"),     KW_BITS'("and"),    KW_BITS'("isnt"),      KW_BITS'("is")
  };

  localparam logic [NUM_KEYWORDS-1:0][3:0] KEYWORD_LEN = {
    4'd5, 4'd4, 4'd2, 4'd7, 4'd5, 4'd6, 4'd5, 4'd3,
    4'd6, 4'd9, 4'd6, 4'd6, 4'd2, 4'd3, 4'd4, 4'd2
  };

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_skip_space(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0d || c == 8'h0b || c == 8'h0c;
  endfunction

  function automatic logic is_single(input logic [7:0] c);
    logic hit;
    hit = (c == 8'h7b) || (c == 8'h7d) || (c == 8'h3b) || (c == 8'h5e);
    for (int i = 0; i < NUM_PUNCT; i++) begin
      if (PUNCT_CHARS[i] == c) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

>>> hdl/stt_classify.sv
// ----------------------------------------------------------------------------
// Token classifier
// Gives the kind of a closed token from its length, first characters and mode.
// ----------------------------------------------------------------------------
module stt_classify (
  input  logic [stt_pkg::LEN_BITS-1:0]  len,
  input  logic [7:0]                    first,
  input  stt_pkg::word_t                word,
  input  logic                          is_real,
  output logic [stt_pkg::KIND_BITS-1:0] kind
);
  import stt_pkg::*;

  always_comb begin
    logic       punct_hit;
    logic [3:0] punct_idx;
    logic       kw_hit;
    logic [3:0] kw_idx;
    logic       match;
    int         sh;
    punct_hit = 1'b0;
    punct_idx = '0;
    kw_hit    = 1'b0;
    kw_idx    = '0;
    for (int i = 0; i < NUM_PUNCT; i++) begin
      if (PUNCT_CHARS[i] == first) begin
        punct_hit = 1'b1;
        punct_idx = 4'(i);
      end
    end
    for (int i = 0; i < NUM_KEYWORDS; i++) begin
      match = (len == LEN_BITS'(KEYWORD_LEN[i]));
      for (int j = 0; j < KW_LEN_MAX; j++) begin
        if (j < int'(KEYWORD_LEN[i])) begin
          sh = int'(KEYWORD_LEN[i]) - 1 - j;
          if (word[j] != KEYWORD_TEXT[i][sh*8 +: 8]) begin
            match = 1'b0;
          end
        end
      end
      if (match) begin
        kw_hit = 1'b1;
        kw_idx = 4'(i);
      end
    end
    if (len == LEN_BITS'(1) && punct_hit) begin
      kind = {2'b00, punct_idx};
    end else if (kw_hit) begin
      kind = KIND_KEYWORD_BASE + {2'b00, kw_idx};
    end else if (is_digit(first)) begin
      kind = is_real ? KIND_REAL : KIND_INT;
    end else if (first == CH_QUOTE) begin
      kind = KIND_CHAR;
    end else if (first == CH_DQUOTE) begin
      kind = KIND_STRING;
    end else begin
      kind = KIND_IDENT;
    end
  end

endmodule

>>> hdl/stt_scanner.sv
// ----------------------------------------------------------------------------
// Scanner
// Holds the scanner state and turns one character into up to three tokens.
// ----------------------------------------------------------------------------
module stt_scanner (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  stt_pkg::in_t    in_data,
  output stt_pkg::batch_t batch
);
  import stt_pkg::*;

  localparam int IDX_BITS = $clog2(KW_LEN_MAX);

  mode_t               mode_r, mode_nxt;
  logic [POS_BITS-1:0] pos_r, pos_nxt;
  logic [POS_BITS-1:0] start_r, start_nxt;
  logic [LEN_BITS-1:0] len_r, len_nxt;
  logic [7:0]          first_r, first_nxt;
  logic [7:0]          word_r [KW_LEN_MAX];

  logic [7:0]          c;
  logic                last;
  logic                close_a, app, close_b;
  mode_t               mid_mode;
  logic [LEN_BITS-1:0] len_base, len_app;
  logic [POS_BITS-1:0] start_app, pos_inc;
  logic [7:0]          first_app;
  word_t               word_old, word_app;
  logic [KIND_BITS-1:0] kind_a, kind_b;
  out_t                tok_a, tok_b, tok_e;
  logic                v_b;

  assign c    = in_data.symbol;
  assign last = in_data.final_symbol;

  always_comb begin
    logic begin_path;
    logic skip_ok;
    begin_path = 1'b0;
    skip_ok    = 1'b0;
    close_a    = 1'b0;
    app        = 1'b0;
    close_b    = 1'b0;
    mid_mode   = mode_r;
    case (mode_r)
      MODE_SKIP: begin
        begin_path = 1'b1;
        skip_ok    = 1'b1;
      end
      MODE_WORD: begin
        if (is_alpha(c) || is_digit(c) || c == CH_UNDERSCORE) begin
          app = 1'b1;
        end else begin
          close_a    = 1'b1;
          begin_path = 1'b1;
          skip_ok    = 1'b1;
        end
      end
      MODE_INTEGER: begin
        if (c == CH_DOT) begin
          app      = 1'b1;
          mid_mode = MODE_REAL;
        end else if (is_digit(c)) begin
          app = 1'b1;
        end else begin
          close_a    = 1'b1;
          begin_path = 1'b1;
          skip_ok    = 1'b1;
        end
      end
      MODE_REAL: begin
        if (is_digit(c)) begin
          app = 1'b1;
        end else begin
          close_a    = 1'b1;
          begin_path = 1'b1;
          skip_ok    = 1'b1;
        end
      end
      MODE_CHAR: begin
        app     = 1'b1;
        close_b = (c == CH_QUOTE);
      end
      MODE_STRING: begin
        app     = 1'b1;
        close_b = (c == CH_DQUOTE);
      end
      default: begin
        begin_path = 1'b1;
      end
    endcase
    if (begin_path) begin
      if (skip_ok && is_skip_space(c)) begin
        mid_mode = MODE_SKIP;
      end else begin
        app = 1'b1;
        if (is_single(c)) begin
          close_b  = 1'b1;
          mid_mode = MODE_SKIP;
        end else if (is_alpha(c)) begin
          mid_mode = MODE_WORD;
        end else if (is_digit(c)) begin
          mid_mode = MODE_INTEGER;
        end else if (c == CH_QUOTE) begin
          mid_mode = MODE_CHAR;
        end else if (c == CH_DQUOTE) begin
          mid_mode = MODE_STRING;
        end else begin
          mid_mode = MODE_BEGIN;
        end
      end
    end
  end

  assign len_base  = close_a ? '0 : len_r;
  assign len_app   = (len_base < LEN_MAX) ? len_base + LEN_BITS'(1) : len_base;
  assign start_app = (len_base == '0) ? pos_r : start_r;
  assign first_app = (len_base == '0) ? c : first_r;
  assign pos_inc   = (pos_r == POS_MAX) ? pos_r : pos_r + POS_BITS'(1);

  always_comb begin
    for (int j = 0; j < KW_LEN_MAX; j++) begin
      word_old[j] = word_r[j];
      word_app[j] = (len_base == LEN_BITS'(j)) ? c : word_r[j];
    end
  end

  stt_classify u_classify_a (
    .len     (len_r),
    .first   (first_r),
    .word    (word_old),
    .is_real (mode_r == MODE_REAL),
    .kind    (kind_a)
  );

  stt_classify u_classify_b (
    .len     (len_app),
    .first   (first_app),
    .word    (word_app),
    .is_real (mid_mode == MODE_REAL),
    .kind    (kind_b)
  );

  assign v_b   = app && (close_b || last);
  assign tok_a = '{token_kind: kind_a, token_start: start_r, token_length: len_r, run_end: 1'b0};
  assign tok_b = '{token_kind: kind_b, token_start: start_app, token_length: len_app,
                   run_end: 1'b0};
  assign tok_e = '{token_kind: KIND_END, token_start: pos_inc, token_length: '0, run_end: 1'b0};

  always_comb begin
    batch.tok[0] = close_a ? tok_a : (v_b ? tok_b : tok_e);
    batch.tok[1] = (close_a && v_b) ? tok_b : tok_e;
    batch.tok[2] = tok_e;
    batch.count  = 2'({1'b0, close_a} + {1'b0, v_b} + {1'b0, last});
    case (batch.count)
      2'd1: batch.tok[0].run_end = 1'b1;
      2'd2: batch.tok[1].run_end = 1'b1;
      2'd3: batch.tok[2].run_end = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    if (last) begin
      mode_nxt  = MODE_BEGIN;
      pos_nxt   = '0;
      start_nxt = '0;
      len_nxt   = '0;
      first_nxt = '0;
    end else begin
      mode_nxt  = close_b ? MODE_SKIP : mid_mode;
      pos_nxt   = pos_inc;
      len_nxt   = close_b ? '0 : (app ? len_app : len_base);
      start_nxt = app ? start_app : start_r;
      first_nxt = app ? first_app : first_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_BEGIN;
      pos_r   <= '0;
      start_r <= '0;
      len_r   <= '0;
      first_r <= '0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      pos_r   <= pos_nxt;
      start_r <= start_nxt;
      len_r   <= len_nxt;
      first_r <= first_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && app && len_base < LEN_BITS'(KW_LEN_MAX)) begin
      word_r[len_base[IDX_BITS-1:0]] <= c;
    end
  end

endmodule

>>> hdl/stt_out_queue.sv
// ----------------------------------------------------------------------------
// Token output queue
// Four-entry shifting queue that takes a batch of tokens and hands out one.
// ----------------------------------------------------------------------------
module stt_out_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  stt_pkg::batch_t batch,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output stt_pkg::out_t   out_data
);
  import stt_pkg::*;

  out_t       q_r   [QUEUE_DEPTH];
  out_t       q_nxt [QUEUE_DEPTH];
  logic [2:0] count_r, count_nxt;
  logic [2:0] base;
  logic       pop;

  assign out_valid = (count_r != '0);
  assign out_data  = q_r[0];
  assign in_ready  = (count_r <= 3'd1);
  assign pop       = out_valid && out_ready;
  assign base      = count_r - {2'b00, pop};
  assign count_nxt = base + (push ? {1'b0, batch.count} : 3'd0);

  always_comb begin
    logic [2:0] rel;
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      q_nxt[k] = q_r[k];
    end
    if (pop) begin
      for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
        q_nxt[k] = q_r[k+1];
      end
    end
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      rel = 3'(k) - base;
      if (push && 3'(k) >= base && rel < {1'b0, batch.count}) begin
        q_nxt[k] = batch.tok[rel[1:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      q_r[k] <= q_nxt[k];
    end
  end

endmodule

>>> hdl/source_text_tokenizer.sv
// ----------------------------------------------------------------------------
// Source text tokenizer
// A character's first token is offered in the next cycle if no older token is left.
// Throughput: one character per cycle while each yields at most one token and
// out_ready is high; the four-entry output queue takes a character only when
// one token or none waits, so a character that yields three tokens holds input.
// Reset: synchronous, clears the scanner to the start of a text and empties the queue.
// ----------------------------------------------------------------------------
module source_text_tokenizer (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  stt_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output stt_pkg::out_t out_data
);
  import stt_pkg::*;

  logic   accept;
  batch_t batch;

  assign accept = in_valid && in_ready;

  stt_scanner u_scanner (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_data (in_data),
    .batch   (batch)
  );

  stt_out_queue u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .batch     (batch),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_final_gives_token: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.final_symbol |=> out_valid)
    else $error("final character produced no token");

  a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("empty queue refuses a request");

  a_end_token_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.token_kind == KIND_END |->
      out_data.run_end && out_data.token_length == '0)
    else $error("end token malformed");

endmodule

>>> tb/tb_source_text_tokenizer.sv
// ----------------------------------------------------------------------------
// Source text tokenizer testbench
// Sends short hand-picked texts, then random texts built mostly from real
// tokens with some noise. A scoreboard predicts the token stream of every
// accepted request and compares each accepted token field by field while both
// sides stall at random, but for a quiet tail at the end of the random texts.
// ----------------------------------------------------------------------------
module tb_source_text_tokenizer;

  import stt_pkg::*;

  localparam int CYCLE_LIMIT    = 100_000;
  localparam int RANDOM_SYMBOLS = 300;
  localparam int QUIET_SYMBOLS  = 40;
  localparam int SETTLE_CYCLES  = 16;

  typedef enum logic [KIND_BITS-1:0] {
    TOK_LPAREN, TOK_RPAREN, TOK_LBRACKET, TOK_RBRACKET, TOK_NEWLINE, TOK_TILDE,
    TOK_COMMA, TOK_DOT, TOK_COLON, TOK_PLUS, TOK_MINUS, TOK_SLASH, TOK_STAR,
    TOK_EQUAL, TOK_LESS, TOK_GREATER
  } punct_kind_t;

  typedef enum logic [3:0] {
    PIECE_KEYWORD, PIECE_WORD, PIECE_INTEGER, PIECE_REAL, PIECE_CHAR, PIECE_STRING,
    PIECE_SINGLE, PIECE_SPACE, PIECE_NEWLINE, PIECE_NOISE
  } piece_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b1;
  out_t out_data;

  bit sender_idles = 1'b0;
  bit quiet_tail = 1'b0;
  int hold_left = 0;
  int cycle_count = 0;
  int mismatches = 0;

  string singles = "{}[]();,.+-*/^><=\n~:";
  string blanks = "\040\011\015\013\014";
  logic [7:0] draft_text[$];

  // Scanner state of the prediction.
  mode_t               scan_mode;
  logic [POS_BITS-1:0] next_pos;
  logic [POS_BITS-1:0] tok_start;
  logic [LEN_BITS-1:0] tok_len;
  logic [7:0]          tok_first;
  logic [7:0]          tok_chars[KW_LEN_MAX];
  out_t                predicted_tokens[$];

  source_text_tokenizer i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #4 clk = ~clk;

  function automatic string keyword_text(input int k);
    case (k)
      0: return "is";
      1: return "isnt";
      2: return "and";
      3: return "or";
      4: return "module";
      5: return "struct";
      6: return "interface";
      7: return "return";
      8: return "end";
      9: return "array";
      10: return "static";
      11: return "const";
      12: return "private";
      13: return "if";
      14: return "else";
      default: return "while";
    endcase
  endfunction

  function automatic bit is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_numeral(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    case (c)
      8'h20, 8'h09, 8'h0d, 8'h0b, 8'h0c: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit ends_alone(input logic [7:0] c);
    case (c)
      "{", "}", "[", "]", "(", ")", ";", ",", ".", "+", "-", "*", "/", "^", ">", "<",
      "=", "\n", "~", ":": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic void clear_scanner();
    scan_mode = MODE_BEGIN;
    next_pos  = '0;
    tok_start = '0;
    tok_len   = '0;
    tok_first = '0;
  endfunction

  function automatic logic [KIND_BITS-1:0] closing_kind();
    string kw;
    bit    hit;
    int    k;
    int    j;
    if (tok_len == 1) begin
      case (tok_first)
        "(": return TOK_LPAREN;
        ")": return TOK_RPAREN;
        "[": return TOK_LBRACKET;
        "]": return TOK_RBRACKET;
        "\n": return TOK_NEWLINE;
        "~": return TOK_TILDE;
        ",": return TOK_COMMA;
        ".": return TOK_DOT;
        ":": return TOK_COLON;
        "+": return TOK_PLUS;
        "-": return TOK_MINUS;
        "/": return TOK_SLASH;
        "*": return TOK_STAR;
        "=": return TOK_EQUAL;
        "<": return TOK_LESS;
        ">": return TOK_GREATER;
        default: ;
      endcase
    end
    for (k = 0; k < NUM_KEYWORDS; k++) begin
      kw = keyword_text(k);
      if (tok_len == kw.len() && kw.len() <= KW_LEN_MAX) begin
        hit = 1'b1;
        for (j = 0; j < kw.len(); j++) begin
          if (tok_chars[j] != kw[j]) hit = 1'b0;
        end
        if (hit) return KIND_KEYWORD_BASE + KIND_BITS'(k);
      end
    end
    if (is_numeral(tok_first)) return (scan_mode == MODE_REAL) ? KIND_REAL : KIND_INT;
    if (tok_first == CH_QUOTE) return KIND_CHAR;
    if (tok_first == CH_DQUOTE) return KIND_STRING;
    return KIND_IDENT;
  endfunction

  function automatic void push_token(input logic [KIND_BITS-1:0] kind,
                                     input logic [POS_BITS-1:0] start,
                                     input logic [LEN_BITS-1:0] len);
    out_t t;
    t.token_kind   = kind;
    t.token_start  = start;
    t.token_length = len;
    t.run_end      = 1'b0;
    predicted_tokens.push_back(t);
  endfunction

  function automatic void close_token();
    push_token(closing_kind(), tok_start, tok_len);
    tok_len   = '0;
    scan_mode = MODE_SKIP;
  endfunction

  function automatic void extend_token(input logic [7:0] c);
    if (tok_len == 0) begin
      tok_start = next_pos;
      tok_first = c;
    end
    if (tok_len < KW_LEN_MAX) tok_chars[tok_len] = c;
    if (tok_len != LEN_MAX) tok_len = tok_len + 1'b1;
  endfunction

  function automatic void start_token(input logic [7:0] c);
    extend_token(c);
    if (ends_alone(c)) close_token();
    else if (is_letter(c)) scan_mode = MODE_WORD;
    else if (is_numeral(c)) scan_mode = MODE_INTEGER;
    else if (c == CH_QUOTE) scan_mode = MODE_CHAR;
    else if (c == CH_DQUOTE) scan_mode = MODE_STRING;
    else scan_mode = MODE_BEGIN;
  endfunction

  function automatic void skip_or_start(input logic [7:0] c);
    if (!is_blank(c)) start_token(c);
  endfunction

  function automatic void scan_symbol(input in_t req);
    logic [7:0] c;
    int         before_count;
    out_t       tail;
    c = req.symbol;
    before_count = predicted_tokens.size();
    case (scan_mode)
      MODE_SKIP: skip_or_start(c);
      MODE_WORD: begin
        if (is_letter(c) || is_numeral(c) || c == CH_UNDERSCORE) extend_token(c);
        else begin
          close_token();
          skip_or_start(c);
        end
      end
      MODE_INTEGER: begin
        if (c == CH_DOT) begin
          extend_token(c);
          scan_mode = MODE_REAL;
        end else if (is_numeral(c)) begin
          extend_token(c);
        end else begin
          close_token();
          skip_or_start(c);
        end
      end
      MODE_REAL: begin
        if (is_numeral(c)) extend_token(c);
        else begin
          close_token();
          skip_or_start(c);
        end
      end
      MODE_CHAR: begin
        extend_token(c);
        if (c == CH_QUOTE) close_token();
      end
      MODE_STRING: begin
        extend_token(c);
        if (c == CH_DQUOTE) close_token();
      end
      default: start_token(c);
    endcase
    if (next_pos != POS_MAX) next_pos = next_pos + 1'b1;
    if (req.final_symbol) begin
      if (tok_len != 0) close_token();
      push_token(KIND_END, next_pos, '0);
      clear_scanner();
    end
    if (predicted_tokens.size() > before_count) begin
      tail = predicted_tokens.pop_back();
      tail.run_end = 1'b1;
      predicted_tokens.push_back(tail);
    end
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    out_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("source_text_tokenizer test failed");
      $finish;
    end else if (rst_n) begin
      if (in_valid && in_ready) scan_symbol(in_data);
      if (out_valid && out_ready) begin
        if (predicted_tokens.size() == 0) begin
          $error("token_kind: expected none, actual %0d", out_data.token_kind);
          mismatches++;
        end else begin
          want = predicted_tokens.pop_front();
          compare_field("token_kind", 32'(want.token_kind), 32'(out_data.token_kind));
          compare_field("token_start", 32'(want.token_start), 32'(out_data.token_start));
          compare_field("token_length", 32'(want.token_length),
                        32'(out_data.token_length));
          compare_field("run_end", 32'(want.run_end), 32'(out_data.run_end));
        end
      end
    end
  end

  // Random output stalls, separated by short gaps or by long stretches without any.
  always @(posedge clk) begin
    if (!rst_n || quiet_tail) begin
      out_ready <= 1'b1;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (out_ready && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      hold_left <= $urandom_range(0, 8);
    end else if (!out_ready) begin
      out_ready <= 1'b1;
      hold_left <= ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(10, 40);
    end
  end

  task automatic send_symbol(input logic [7:0] sym, input logic is_final);
    if (sender_idles && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{symbol: sym, final_symbol: is_final};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_symbol(s[i], i == s.len() - 1);
  endtask

  task automatic wait_for_tokens();
    in_valid <= 1'b0;
    @(posedge clk);
    while (predicted_tokens.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] random_letter();
    return ($urandom_range(0, 1) == 0) ? 8'($urandom_range("a", "z")) :
                                         8'($urandom_range("A", "Z"));
  endfunction

  function automatic logic [7:0] random_digit();
    return 8'($urandom_range("0", "9"));
  endfunction

  function automatic logic [7:0] word_tail_char();
    case ($urandom_range(0, 3))
      0: return random_digit();
      1: return CH_UNDERSCORE;
      default: return random_letter();
    endcase
  endfunction

  function automatic logic [7:0] literal_char(input logic [7:0] closer);
    logic [7:0] c;
    c = 8'($urandom_range(8'h20, 8'h7e));
    return (c == closer) ? "z" : c;
  endfunction

  task automatic compose_text();
    piece_t pick;
    string  kw;
    int     k;
    draft_text.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6)) draft_text.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 8)) begin
        pick = piece_t'($urandom_range(0, PIECE_NOISE));
        case (pick)
          PIECE_KEYWORD: begin
            kw = keyword_text($urandom_range(0, NUM_KEYWORDS - 1));
            for (k = 0; k < kw.len(); k++) draft_text.push_back(kw[k]);
          end
          PIECE_WORD: begin
            draft_text.push_back(random_letter());
            repeat ($urandom_range(0, 6)) draft_text.push_back(word_tail_char());
          end
          PIECE_INTEGER: repeat ($urandom_range(1, 5)) draft_text.push_back(random_digit());
          PIECE_REAL: begin
            repeat ($urandom_range(1, 3)) draft_text.push_back(random_digit());
            draft_text.push_back(CH_DOT);
            repeat ($urandom_range(0, 3)) draft_text.push_back(random_digit());
          end
          PIECE_CHAR: begin
            draft_text.push_back(CH_QUOTE);
            repeat ($urandom_range(0, 2)) draft_text.push_back(literal_char(CH_QUOTE));
            draft_text.push_back(CH_QUOTE);
          end
          PIECE_STRING: begin
            draft_text.push_back(CH_DQUOTE);
            repeat ($urandom_range(0, 5)) draft_text.push_back(literal_char(CH_DQUOTE));
            draft_text.push_back(CH_DQUOTE);
          end
          PIECE_SINGLE: draft_text.push_back(singles[$urandom_range(0, singles.len() - 1)]);
          PIECE_SPACE: begin
            repeat ($urandom_range(1, 3)) begin
              draft_text.push_back(blanks[$urandom_range(0, blanks.len() - 1)]);
            end
          end
          PIECE_NEWLINE: draft_text.push_back("\n");
          default: draft_text.push_back(8'($urandom_range(0, 255)));
        endcase
      end
    end
  endtask

  task automatic test_directed_texts();
    sender_idles = 1'b1;
    send_text(" if");
    send_text("7.5 ");
    send_text("'q'\"s");
    send_symbol(8'h00, 1'b0);
    send_symbol(8'hff, 1'b0);
    send_symbol("^", 1'b1);
    send_text("while{");
    send_text("(~");
  endtask

  task automatic test_random_texts();
    int  sent;
    int  n;
    bit  drained;
    sent = 0;
    drained = 1'b0;
    while (sent < RANDOM_SYMBOLS) begin
      if (sent >= RANDOM_SYMBOLS - QUIET_SYMBOLS) begin
        quiet_tail = 1'b1;
        sender_idles = 1'b0;
      end else begin
        sender_idles = ($urandom_range(0, 3) != 0);
      end
      compose_text();
      for (n = 0; n < draft_text.size(); n++) begin
        send_symbol(draft_text[n], n == draft_text.size() - 1);
      end
      sent += draft_text.size();
      if (!drained && sent >= RANDOM_SYMBOLS / 2) begin
        wait_for_tokens();
        drained = 1'b1;
      end
    end
  endtask

  initial begin
    clear_scanner();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_texts();
    wait_for_tokens();
    test_random_texts();
    wait_for_tokens();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("source_text_tokenizer test passed");
    end else begin
      $display("source_text_tokenizer test failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/stt_pkg.sv
hdl/stt_classify.sv
hdl/stt_scanner.sv
hdl/stt_out_queue.sv
hdl/source_text_tokenizer.sv
tb/tb_source_text_tokenizer.sv
